// File: rtl/core/mact_pkg.sv
// Package: shared types, field widths and constants of the alarm clock timer.
`default_nettype none

package mact_pkg;

    // Field widths
    localparam int W_REQ   = 2;
    localparam int W_ADC   = 10;
    localparam int W_BUZZ  = 2;
    localparam int W_MODE  = 3;
    localparam int W_HOUR  = 5;
    localparam int W_MIN   = 6;
    localparam int W_THOUR = 7;
    localparam int W_TICK  = 7;
    localparam int W_LIMIT = 10;

    // Request codes
    typedef enum logic [W_REQ-1:0] {
        REQ_TICK    = 2'd0,
        REQ_BTN_ONE = 2'd1,
        REQ_BTN_TWO = 2'd2
    } t_req;

    // Operating modes
    typedef enum logic [W_MODE-1:0] {
        MODE_NONE  = 3'd0,
        MODE_CLOCK = 3'd1,
        MODE_TIMER = 3'd2,
        MODE_ALARM = 3'd3,
        MODE_LIGHT = 3'd4
    } t_mode;

    // Buzzer tones
    typedef enum logic [W_BUZZ-1:0] {
        BUZZ_OFF   = 2'd0,
        BUZZ_SHORT = 2'd1,
        BUZZ_LONG  = 2'd2
    } t_buzz;

    // Knob bands
    localparam logic [W_ADC-1:0] KNOB_TIMER_MIN = 10'd256;
    localparam logic [W_ADC-1:0] KNOB_ALARM_MIN = 10'd512;
    localparam logic [W_ADC-1:0] KNOB_LIGHT_MIN = 10'd768;

    // Clock and timer limits
    localparam logic [W_TICK-1:0]  TICK_LAST        = 7'd119;
    localparam logic [W_MIN-1:0]   MINUTE_LAST      = 6'd59;
    localparam logic [W_HOUR-1:0]  HOUR_LAST        = 5'd23;
    localparam logic [W_THOUR-1:0] TIMER_HOUR_MAX   = 7'd99;
    localparam logic [W_MIN-1:0]   TIMER_RELOAD_MIN = 6'd1;
    localparam logic [W_MIN-1:0]   TIMER_RELOAD_SEC = 6'd5;

    // Light threshold limits
    localparam logic [W_LIMIT-1:0] LIMIT_RESET = 10'd200;
    localparam logic [W_LIMIT-1:0] LIMIT_STEP  = 10'd100;
    localparam logic [W_LIMIT-1:0] LIMIT_MIN   = 10'd100;
    localparam logic [W_LIMIT-1:0] LIMIT_LOW   = 10'd200;
    localparam logic [W_LIMIT-1:0] LIMIT_HIGH  = 10'd900;
    localparam logic [W_LIMIT-1:0] LIMIT_MAX   = 10'd1000;

endpackage

`default_nettype wire

// File: rtl/core/mact_if.sv
// Interfaces: request and response channels of the alarm clock timer.
`default_nettype none

interface mact_req_if
    import mact_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [W_REQ-1:0]   req_type;
    logic [W_ADC-1:0]   knob_reading;
    logic [W_ADC-1:0]   light_level;

    modport source (output valid, output req_type, output knob_reading,
                    output light_level, input ready);
    modport sink   (input valid, input req_type, input knob_reading,
                    input light_level, output ready);
endinterface

interface mact_rsp_if
    import mact_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [W_BUZZ-1:0]  buzz;
    logic [W_MODE-1:0]  current_mode;
    logic [W_HOUR-1:0]  clock_hours;
    logic [W_MIN-1:0]   clock_minutes;
    logic [W_THOUR-1:0] countdown_hours;
    logic [W_MIN-1:0]   countdown_minutes;
    logic [W_MIN-1:0]   countdown_seconds;
    logic [W_HOUR-1:0]  wake_hours;
    logic [W_MIN-1:0]   wake_minutes;
    logic [W_LIMIT-1:0] light_limit;

    modport source (output valid, output buzz, output current_mode,
                    output clock_hours, output clock_minutes,
                    output countdown_hours, output countdown_minutes,
                    output countdown_seconds, output wake_hours,
                    output wake_minutes, output light_limit, input ready);
    modport sink   (input valid, input buzz, input current_mode,
                    input clock_hours, input clock_minutes,
                    input countdown_hours, input countdown_minutes,
                    input countdown_seconds, input wake_hours,
                    input wake_minutes, input light_limit, output ready);
endinterface

`default_nettype wire

// File: rtl/core/multimode_alarm_clock_timer.sv
// Top level: multimode alarm clock with countdown timer and light alarm.
//
//  Channel  Dir  Payload                                        Handshake
//  i_req    in   req_type, knob_reading, light_level            valid/ready
//  o_rsp    out  buzz, mode, clock, countdown, wake, light_limit valid/ready
//
// Each transaction passes an input register, the update logic and the
// result register; o_rsp.valid rises when the result register takes it.
// One transaction is taken every cycle unless o_rsp stalls; the input register
// refills while a finished result waits, so only o_rsp.ready limits throughput.
// A stall on o_rsp holds both registers and the clock state.
// Synchronous active-low reset clears the clock state to its power-up values.
`default_nettype none

module multimode_alarm_clock_timer
    import mact_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mact_req_if.sink   i_req,
    mact_rsp_if.source o_rsp
);

    // Input register
    logic               r_in_valid;
    logic [W_REQ-1:0]   r_req_type;
    logic [W_ADC-1:0]   r_knob;
    logic [W_ADC-1:0]   r_light;

    // Clock state, which is also the shown result
    t_mode              r_mode,         n_mode;
    logic [W_TICK-1:0]  r_half_count,   n_half_count;
    logic [W_HOUR-1:0]  r_hour,         n_hour;
    logic [W_MIN-1:0]   r_minute,       n_minute;
    logic [W_HOUR-1:0]  r_wake_hour,    n_wake_hour;
    logic [W_MIN-1:0]   r_wake_minute,  n_wake_minute;
    logic [W_THOUR-1:0] r_tmr_hour,     n_tmr_hour;
    logic [W_MIN-1:0]   r_tmr_minute,   n_tmr_minute;
    logic [W_MIN-1:0]   r_tmr_second,   n_tmr_second;
    logic               r_tmr_phase,    n_tmr_phase;
    logic [W_LIMIT-1:0] r_limit,        n_limit;

    // Result register
    logic               r_out_valid;
    t_buzz              r_out_buzz,     n_buzz;

    logic               advance;

    // Move the held transaction on when the result slot is free or drains
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    // Capture an incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_knob     <= i_req.knob_reading;
            r_light    <= i_req.light_level;
        end
    end

    // Compute the state after the held transaction
    always_comb begin
        n_mode        = r_mode;
        n_half_count  = r_half_count;
        n_hour        = r_hour;
        n_minute      = r_minute;
        n_wake_hour   = r_wake_hour;
        n_wake_minute = r_wake_minute;
        n_tmr_hour    = r_tmr_hour;
        n_tmr_minute  = r_tmr_minute;
        n_tmr_second  = r_tmr_second;
        n_tmr_phase   = r_tmr_phase;
        n_limit       = r_limit;
        n_buzz        = BUZZ_OFF;

        case (r_req_type)
            REQ_TICK: begin
                if (r_knob < KNOB_TIMER_MIN) begin
                    n_mode = MODE_CLOCK;
                end else if (r_knob < KNOB_ALARM_MIN) begin
                    n_mode      = MODE_TIMER;
                    n_tmr_phase = !r_tmr_phase;
                    // count down one second on every second tick, never below zero
                    if (r_tmr_phase) begin
                        if (r_tmr_second != '0) begin
                            n_tmr_second = r_tmr_second - 6'd1;
                        end else if (r_tmr_minute != '0) begin
                            n_tmr_second = MINUTE_LAST;
                            n_tmr_minute = r_tmr_minute - 6'd1;
                        end else if (r_tmr_hour != '0) begin
                            n_tmr_second = MINUTE_LAST;
                            n_tmr_minute = MINUTE_LAST;
                            n_tmr_hour   = r_tmr_hour - 7'd1;
                        end
                    end
                    // sound and reload once the countdown shows zero
                    if (n_tmr_hour == '0 && n_tmr_minute == '0 && n_tmr_second == '0) begin
                        n_tmr_minute = TIMER_RELOAD_MIN;
                        n_tmr_second = TIMER_RELOAD_SEC;
                        n_buzz       = BUZZ_LONG;
                    end
                end else if (r_knob < KNOB_LIGHT_MIN) begin
                    n_mode = MODE_ALARM;
                    if (r_wake_minute == r_minute && r_wake_hour == r_hour) begin
                        n_buzz = BUZZ_SHORT;
                    end
                end else begin
                    n_mode = MODE_LIGHT;
                    if (r_light > r_limit) begin
                        n_buzz = BUZZ_LONG;
                    end
                end

                // advance the time of day one minute per 120 ticks
                if (r_half_count == TICK_LAST) begin
                    n_half_count = '0;
                    if (r_minute == MINUTE_LAST) begin
                        n_minute = '0;
                        n_hour   = (r_hour == HOUR_LAST) ? '0 : r_hour + 5'd1;
                    end else begin
                        n_minute = r_minute + 6'd1;
                    end
                end else begin
                    n_half_count = r_half_count + 7'd1;
                end
            end
            REQ_BTN_ONE: begin
                case (r_mode)
                    MODE_CLOCK: begin
                        n_hour = (r_hour == HOUR_LAST) ? '0 : r_hour + 5'd1;
                    end
                    MODE_TIMER: begin
                        if (r_tmr_hour < TIMER_HOUR_MAX) begin
                            n_tmr_hour = r_tmr_hour + 7'd1;
                        end
                    end
                    MODE_ALARM: begin
                        n_wake_hour = (r_wake_hour == HOUR_LAST) ? '0 : r_wake_hour + 5'd1;
                    end
                    default: begin
                        n_limit = (r_limit <= LIMIT_LOW) ? LIMIT_MIN : r_limit - LIMIT_STEP;
                    end
                endcase
            end
            REQ_BTN_TWO: begin
                case (r_mode)
                    MODE_CLOCK: begin
                        n_minute = (r_minute == MINUTE_LAST) ? '0 : r_minute + 6'd1;
                    end
                    MODE_TIMER: begin
                        n_tmr_minute = (r_tmr_minute == MINUTE_LAST) ? '0
                                                                     : r_tmr_minute + 6'd1;
                    end
                    MODE_ALARM: begin
                        n_wake_minute = (r_wake_minute == MINUTE_LAST) ? '0
                                                                       : r_wake_minute + 6'd1;
                    end
                    default: begin
                        n_limit = (r_limit >= LIMIT_HIGH) ? LIMIT_MAX : r_limit + LIMIT_STEP;
                    end
                endcase
            end
            default: begin
                // unknown request: show the state unchanged
            end
        endcase
    end

    // Commit the new state together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_mode        <= MODE_NONE;
            r_half_count  <= '0;
            r_hour        <= '0;
            r_minute      <= '0;
            r_wake_hour   <= '0;
            r_wake_minute <= '0;
            r_tmr_hour    <= '0;
            r_tmr_minute  <= TIMER_RELOAD_MIN;
            r_tmr_second  <= '0;
            r_tmr_phase   <= 1'b0;
            r_limit       <= LIMIT_RESET;
        end else begin
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_mode        <= n_mode;
                r_half_count  <= n_half_count;
                r_hour        <= n_hour;
                r_minute      <= n_minute;
                r_wake_hour   <= n_wake_hour;
                r_wake_minute <= n_wake_minute;
                r_tmr_hour    <= n_tmr_hour;
                r_tmr_minute  <= n_tmr_minute;
                r_tmr_second  <= n_tmr_second;
                r_tmr_phase   <= n_tmr_phase;
                r_limit       <= n_limit;
            end else if (o_rsp.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
        if (advance) begin
            r_out_buzz <= n_buzz;
        end
    end

    // Drive the response channel
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.buzz              = r_out_buzz;
    assign o_rsp.current_mode      = r_mode;
    assign o_rsp.clock_hours       = r_hour;
    assign o_rsp.clock_minutes     = r_minute;
    assign o_rsp.countdown_hours   = r_tmr_hour;
    assign o_rsp.countdown_minutes = r_tmr_minute;
    assign o_rsp.countdown_seconds = r_tmr_second;
    assign o_rsp.wake_hours        = r_wake_hour;
    assign o_rsp.wake_minutes      = r_wake_minute;
    assign o_rsp.light_limit       = r_limit;

endmodule

`default_nettype wire

// File: rtl/core/mact_checker.sv
// Checker: port-level assertions for the alarm clock timer, bound to the top level.
`default_nettype none

module mact_checker
    import mact_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [W_BUZZ-1:0]  i_buzz,
    input wire logic [W_MODE-1:0]  i_mode,
    input wire logic [W_HOUR-1:0]  i_clock_hours,
    input wire logic [W_MIN-1:0]   i_clock_minutes,
    input wire logic [W_THOUR-1:0] i_cd_hours,
    input wire logic [W_MIN-1:0]   i_cd_minutes,
    input wire logic [W_MIN-1:0]   i_cd_seconds,
    input wire logic [W_HOUR-1:0]  i_wake_hours,
    input wire logic [W_MIN-1:0]   i_wake_minutes,
    input wire logic [W_LIMIT-1:0] i_light_limit
);

    // No result is offered right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("response valid right after reset");

    // A stalled response holds its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_buzz)
            && $stable(i_clock_minutes) && $stable(i_cd_seconds)
            && $stable(i_light_limit) && $stable(i_mode))
        else $error("stalled response changed");

    // Every shown time and limit stays in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_clock_hours <= HOUR_LAST && i_clock_minutes <= MINUTE_LAST
            && i_wake_hours <= HOUR_LAST && i_wake_minutes <= MINUTE_LAST
            && i_cd_hours <= TIMER_HOUR_MAX && i_cd_minutes <= MINUTE_LAST
            && i_cd_seconds <= MINUTE_LAST
            && i_light_limit >= LIMIT_MIN && i_light_limit <= LIMIT_MAX)
        else $error("response field out of range");

    // A short tone comes only from the wake alarm
    a_short_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_buzz == BUZZ_SHORT |-> i_mode == MODE_ALARM)
        else $error("short tone outside alarm mode");

    // A long tone comes only in light mode, or in timer mode with the reloaded countdown
    a_long_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_buzz == BUZZ_LONG |->
            i_mode == MODE_LIGHT || (i_mode == MODE_TIMER && i_cd_hours == '0
                && i_cd_minutes == TIMER_RELOAD_MIN && i_cd_seconds == TIMER_RELOAD_SEC))
        else $error("long tone without timer reload or light mode");

endmodule

bind multimode_alarm_clock_timer mact_checker u_mact_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_buzz          (o_rsp.buzz),
    .i_mode          (o_rsp.current_mode),
    .i_clock_hours   (o_rsp.clock_hours),
    .i_clock_minutes (o_rsp.clock_minutes),
    .i_cd_hours      (o_rsp.countdown_hours),
    .i_cd_minutes    (o_rsp.countdown_minutes),
    .i_cd_seconds    (o_rsp.countdown_seconds),
    .i_wake_hours    (o_rsp.wake_hours),
    .i_wake_minutes  (o_rsp.wake_minutes),
    .i_light_limit   (o_rsp.light_limit)
);

`default_nettype wire

// File: test/tb_top.sv
// Testbench: alarm clock timer checked against a cycle-free model of its displayed state.
`timescale 1ns / 1ps

import mact_pkg::*;

// One displayed result of the block
typedef struct {
    t_buzz              buzz;
    t_mode              mode;
    logic [W_HOUR-1:0]  clk_hour;
    logic [W_MIN-1:0]   clk_minute;
    logic [W_THOUR-1:0] cd_hour;
    logic [W_MIN-1:0]   cd_minute;
    logic [W_MIN-1:0]   cd_second;
    logic [W_HOUR-1:0]  wake_hour;
    logic [W_MIN-1:0]   wake_minute;
    logic [W_LIMIT-1:0] limit;
} t_face;

class alarm_face_checker;
    // Mirrored clock state
    t_mode              mode;
    logic [W_TICK-1:0]  half_ticks;
    logic [W_HOUR-1:0]  hour;
    logic [W_MIN-1:0]   minute;
    logic [W_HOUR-1:0]  wake_hour;
    logic [W_MIN-1:0]   wake_minute;
    logic [W_THOUR-1:0] cd_hour;
    logic [W_MIN-1:0]   cd_minute;
    logic [W_MIN-1:0]   cd_second;
    logic               cd_phase;
    logic [W_LIMIT-1:0] limit;

    t_face expected_faces[$];
    int    n_faces;
    int    errors;

    function new();
        mode        = MODE_NONE;
        half_ticks  = '0;
        hour        = '0;
        minute      = '0;
        wake_hour   = '0;
        wake_minute = '0;
        cd_hour     = '0;
        cd_minute   = TIMER_RELOAD_MIN;
        cd_second   = '0;
        cd_phase    = 1'b0;
        limit       = LIMIT_RESET;
        n_faces     = 0;
        errors      = 0;
    endfunction

    // Advance the countdown by half a second; long tone and reload at zero
    function t_buzz run_countdown();
        if (!cd_phase) begin
            cd_phase = 1'b1;
        end else begin
            cd_phase = 1'b0;
            if (cd_second != 0) begin
                cd_second = cd_second - 1'b1;
            end else if (cd_minute != 0) begin
                cd_second = MINUTE_LAST;
                cd_minute = cd_minute - 1'b1;
            end else if (cd_hour != 0) begin
                cd_second = MINUTE_LAST;
                cd_minute = MINUTE_LAST;
                cd_hour   = cd_hour - 1'b1;
            end
        end
        if (cd_hour == 0 && cd_minute == 0 && cd_second == 0) begin
            cd_minute = TIMER_RELOAD_MIN;
            cd_second = TIMER_RELOAD_SEC;
            return BUZZ_LONG;
        end
        return BUZZ_OFF;
    endfunction

    // Apply one accepted event and queue the display it should produce
    function void note_event(logic [W_REQ-1:0] req, logic [W_ADC-1:0] knob,
                             logic [W_ADC-1:0] light);
        t_face f;
        t_buzz tone;
        tone = BUZZ_OFF;
        case (req)
            REQ_TICK: begin
                if (knob < KNOB_TIMER_MIN) begin
                    mode = MODE_CLOCK;
                end else if (knob < KNOB_ALARM_MIN) begin
                    mode = MODE_TIMER;
                    tone = run_countdown();
                end else if (knob < KNOB_LIGHT_MIN) begin
                    mode = MODE_ALARM;
                    if (wake_hour == hour && wake_minute == minute) tone = BUZZ_SHORT;
                end else begin
                    mode = MODE_LIGHT;
                    if (light > limit) tone = BUZZ_LONG;
                end
                if (half_ticks == TICK_LAST) begin
                    half_ticks = '0;
                    if (minute == MINUTE_LAST) begin
                        minute = '0;
                        hour   = (hour == HOUR_LAST) ? '0 : hour + 1'b1;
                    end else begin
                        minute = minute + 1'b1;
                    end
                end else begin
                    half_ticks = half_ticks + 1'b1;
                end
            end
            REQ_BTN_ONE: begin
                case (mode)
                    MODE_CLOCK: hour = (hour == HOUR_LAST) ? '0 : hour + 1'b1;
                    MODE_TIMER: if (cd_hour < TIMER_HOUR_MAX) cd_hour = cd_hour + 1'b1;
                    MODE_ALARM: wake_hour = (wake_hour == HOUR_LAST) ? '0 : wake_hour + 1'b1;
                    default: begin
                        if (limit <= LIMIT_LOW) limit = LIMIT_MIN;
                        else limit = limit - LIMIT_STEP;
                    end
                endcase
            end
            REQ_BTN_TWO: begin
                case (mode)
                    MODE_CLOCK: minute = (minute == MINUTE_LAST) ? '0 : minute + 1'b1;
                    MODE_TIMER: cd_minute = (cd_minute == MINUTE_LAST) ? '0 : cd_minute + 1'b1;
                    MODE_ALARM: begin
                        wake_minute = (wake_minute == MINUTE_LAST) ? '0 : wake_minute + 1'b1;
                    end
                    default: begin
                        if (limit >= LIMIT_HIGH) limit = LIMIT_MAX;
                        else limit = limit + LIMIT_STEP;
                    end
                endcase
            end
            default: ;  // unknown request: state holds, silent
        endcase
        f.buzz        = tone;
        f.mode        = mode;
        f.clk_hour    = hour;
        f.clk_minute  = minute;
        f.cd_hour     = cd_hour;
        f.cd_minute   = cd_minute;
        f.cd_second   = cd_second;
        f.wake_hour   = wake_hour;
        f.wake_minute = wake_minute;
        f.limit       = limit;
        expected_faces.push_back(f);
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Compare one displayed result with the oldest pending one
    task check_face(t_face got);
        t_face want;
        string diff;
        if (expected_faces.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending", n_faces));
            n_faces++;
            return;
        end
        want = expected_faces.pop_front();
        diff = "";
        if (got.buzz !== want.buzz)
            diff = {diff, $sformatf(" buzz %0d/%0d", got.buzz, want.buzz)};
        if (got.mode !== want.mode)
            diff = {diff, $sformatf(" mode %0d/%0d", got.mode, want.mode)};
        if (got.clk_hour !== want.clk_hour)
            diff = {diff, $sformatf(" hour %0d/%0d", got.clk_hour, want.clk_hour)};
        if (got.clk_minute !== want.clk_minute)
            diff = {diff, $sformatf(" minute %0d/%0d", got.clk_minute, want.clk_minute)};
        if (got.cd_hour !== want.cd_hour)
            diff = {diff, $sformatf(" cd_hour %0d/%0d", got.cd_hour, want.cd_hour)};
        if (got.cd_minute !== want.cd_minute)
            diff = {diff, $sformatf(" cd_min %0d/%0d", got.cd_minute, want.cd_minute)};
        if (got.cd_second !== want.cd_second)
            diff = {diff, $sformatf(" cd_sec %0d/%0d", got.cd_second, want.cd_second)};
        if (got.wake_hour !== want.wake_hour)
            diff = {diff, $sformatf(" wake_hour %0d/%0d", got.wake_hour, want.wake_hour)};
        if (got.wake_minute !== want.wake_minute)
            diff = {diff, $sformatf(" wake_min %0d/%0d", got.wake_minute, want.wake_minute)};
        if (got.limit !== want.limit)
            diff = {diff, $sformatf(" limit %0d/%0d", got.limit, want.limit)};
        if (diff != "")
            report_mismatch($sformatf("result %0d (got/want):%s", n_faces, diff));
        n_faces++;
    endtask
endclass

module tb_top;

    localparam int RANDOM_ITEMS = 900;
    localparam int SATURATE_AT  = 750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;

    mact_req_if req_ch ();
    mact_rsp_if rsp_ch ();

    multimode_alarm_clock_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    alarm_face_checker faces;
    int  n_sent;
    int  req_calm;
    int  rsp_calm;
    int  idle_cycles;
    bit  hours_saturated;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Pick an idle gap: mostly none or short, some long, with calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random reading of full sensor width
    function automatic logic [W_ADC-1:0] rnd_adc();
        return W_ADC'($urandom);
    endfunction

    // Random knob reading inside the band of a mode
    function automatic logic [W_ADC-1:0] knob_for(t_mode m);
        case (m)
            MODE_CLOCK: return W_ADC'($urandom_range(0, KNOB_TIMER_MIN - 1));
            MODE_TIMER: return W_ADC'($urandom_range(KNOB_TIMER_MIN, KNOB_ALARM_MIN - 1));
            MODE_ALARM: return W_ADC'($urandom_range(KNOB_ALARM_MIN, KNOB_LIGHT_MIN - 1));
            default:    return W_ADC'($urandom_range(KNOB_LIGHT_MIN, 1023));
        endcase
    endfunction

    // Present one event and hold it until the block takes the transaction
    task automatic send_event(input logic [W_REQ-1:0] req, input logic [W_ADC-1:0] knob,
                              input logic [W_ADC-1:0] light);
        int gap;
        gap = pick_gap(req_calm);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= req;
        req_ch.knob_reading <= knob;
        req_ch.light_level  <= light;
        do @(posedge i_clk); while (!req_ch.ready);
        faces.note_event(req, knob, light);
        n_sent++;
    endtask

    task automatic tick_in(t_mode m);
        send_event(REQ_TICK, knob_for(m), rnd_adc());
    endtask

    // Count the timer down to a whole minute, then wrap its minutes onto zero
    // so that the next due second finds it already empty
    task automatic drain_countdown_to_zero();
        int guard;
        tick_in(MODE_TIMER);
        guard = 0;
        while (!(faces.cd_second == 0 && faces.cd_phase) && guard < 140) begin
            tick_in(MODE_TIMER);
            guard++;
        end
        if (faces.cd_hour == 0 && faces.cd_second == 0 && faces.cd_phase) begin
            repeat ((60 - int'(faces.cd_minute)) % 60)
                send_event(REQ_BTN_TWO, rnd_adc(), rnd_adc());
            tick_in(MODE_TIMER);
        end
    endtask

    // Drive ready with random stalls
    initial begin
        int n;
        rsp_ch.ready = 1'b0;
        forever begin
            n = pick_gap(rsp_calm);
            if (n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        t_face got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.buzz        = t_buzz'(rsp_ch.buzz);
            got.mode        = t_mode'(rsp_ch.current_mode);
            got.clk_hour    = rsp_ch.clock_hours;
            got.clk_minute  = rsp_ch.clock_minutes;
            got.cd_hour     = rsp_ch.countdown_hours;
            got.cd_minute   = rsp_ch.countdown_minutes;
            got.cd_second   = rsp_ch.countdown_seconds;
            got.wake_hour   = rsp_ch.wake_hours;
            got.wake_minute = rsp_ch.wake_minutes;
            got.limit       = rsp_ch.light_limit;
            faces.check_face(got);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int k;
        int j;
        int lv;
        int random_end;
        logic [W_REQ-1:0] rq;

        faces           = new();
        n_sent          = 0;
        req_calm        = 0;
        rsp_calm        = 0;
        idle_cycles     = 0;
        hours_saturated = 1'b0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_TICK;
        req_ch.knob_reading = '0;
        req_ch.light_level  = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: buttons before any tick step the threshold, clamp at the bottom
        send_event(REQ_BTN_ONE, 10'd1023, 10'd1023);
        send_event(REQ_BTN_ONE, 10'd0, 10'd0);
        send_event(REQ_BTN_TWO, 10'd0, 10'd1023);
        send_event(2'd3, 10'd1023, 10'd1023);
        // Alarm matches the clock right after reset
        send_event(REQ_TICK, 10'd512, 10'd0);
        send_event(REQ_TICK, 10'd767, 10'd1023);
        // Clock set with band edges
        send_event(REQ_TICK, 10'd0, 10'd1023);
        send_event(REQ_BTN_ONE, 10'd0, 10'd0);
        send_event(REQ_BTN_TWO, 10'd1023, 10'd1023);
        send_event(REQ_TICK, 10'd255, 10'd0);
        // Timer: first and second half-second, minute button
        send_event(REQ_TICK, 10'd256, 10'd0);
        send_event(REQ_TICK, 10'd511, 10'd1023);
        send_event(REQ_BTN_TWO, 10'd0, 10'd0);
        // Light: above, far below, equal to and just over the threshold
        send_event(REQ_TICK, 10'd768, 10'd1023);
        send_event(REQ_TICK, 10'd1023, 10'd0);
        send_event(REQ_TICK, 10'd800, 10'd200);
        send_event(REQ_TICK, 10'd900, 10'd201);
        send_event(REQ_BTN_TWO, 10'd0, 10'd0);
        // Alarm set buttons
        send_event(REQ_TICK, 10'd600, 10'd500);
        send_event(REQ_BTN_ONE, 10'd0, 10'd0);
        send_event(REQ_BTN_TWO, 10'd0, 10'd0);
        send_event(2'd3, 10'd0, 10'd0);

        // Random: the timer reaching zero by wrap first, while its hours are still zero
        random_end = n_sent + RANDOM_ITEMS;
        drain_countdown_to_zero();
        drain_countdown_to_zero();
        while (n_sent < random_end) begin
            if (!hours_saturated && n_sent >= SATURATE_AT) begin
                // Push timer hours into saturation
                tick_in(MODE_TIMER);
                repeat (102) send_event(REQ_BTN_ONE, rnd_adc(), rnd_adc());
                repeat (4) tick_in(MODE_TIMER);
                hours_saturated = 1'b1;
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        // Timer run with occasional minute presses
                        k = $urandom_range(5, 80);
                        repeat (k) begin
                            if ($urandom_range(0, 9) == 0)
                                send_event(REQ_BTN_TWO, rnd_adc(), rnd_adc());
                            else
                                tick_in(MODE_TIMER);
                        end
                    end
                    1: begin
                        // Alarm: set the wake time, often onto the clock, then watch
                        tick_in(MODE_ALARM);
                        if ($urandom_range(0, 1) == 1) begin
                            k = (int'(faces.hour) - int'(faces.wake_hour) + 24) % 24;
                            j = (int'(faces.minute) - int'(faces.wake_minute) + 60) % 60;
                        end else begin
                            k = $urandom_range(0, 3);
                            j = $urandom_range(0, 5);
                        end
                        repeat (k) send_event(REQ_BTN_ONE, rnd_adc(), rnd_adc());
                        repeat (j) send_event(REQ_BTN_TWO, rnd_adc(), rnd_adc());
                        repeat ($urandom_range(2, 8)) tick_in(MODE_ALARM);
                    end
                    2: begin
                        // Light: step the threshold, sample around it
                        tick_in(MODE_LIGHT);
                        repeat ($urandom_range(0, 10)) begin
                            rq = ($urandom_range(0, 1) == 1) ? REQ_BTN_TWO : REQ_BTN_ONE;
                            send_event(rq, rnd_adc(), rnd_adc());
                        end
                        repeat ($urandom_range(3, 10)) begin
                            if ($urandom_range(0, 1) == 1)
                                lv = int'(faces.limit) + int'($urandom_range(0, 4)) - 2;
                            else
                                lv = $urandom_range(0, 1023);
                            send_event(REQ_TICK, knob_for(MODE_LIGHT), W_ADC'(lv));
                        end
                    end
                    3: begin
                        // Clock set, sometimes far enough to wrap
                        tick_in(MODE_CLOCK);
                        k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65)
                                                        : $urandom_range(0, 5);
                        j = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 25)
                                                        : $urandom_range(0, 3);
                        repeat (k) send_event(REQ_BTN_TWO, rnd_adc(), rnd_adc());
                        repeat (j) send_event(REQ_BTN_ONE, rnd_adc(), rnd_adc());
                        repeat ($urandom_range(1, 6)) tick_in(MODE_CLOCK);
                    end
                    default: begin
                        // Noise: any request code, any readings
                        repeat ($urandom_range(5, 20)) begin
                            rq = W_REQ'($urandom_range(0, 3));
                            if (rq == REQ_BTN_ONE && faces.mode == MODE_TIMER && !hours_saturated)
                                rq = REQ_BTN_TWO;
                            send_event(rq, rnd_adc(), rnd_adc());
                        end
                    end
                endcase
            end
        end
        req_ch.valid <= 1'b0;

        // Drain and let the pipeline settle
        while (faces.expected_faces.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (faces.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
